[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

[rtl/core/mplo_pkg.sv]
// Package with constants and helpers for the max projection and label overlay block.
package mplo_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_SLICES = 4096;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 9;
    localparam int FH_W       = 9;
    localparam int SC_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SLICE_COUNT  = 2'd2
    } cfg_index_t;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [SC_W-1:0] RST_SLICE_COUNT  = 13'd1;

    localparam logic [PIX_W-1:0] LABEL_MARK = 8'd255;

    // Last valid position for a count register: zero counts as one and
    // anything above the maximum counts as the maximum.
    function automatic logic [31:0] count_limit(input logic [31:0] value,
                                                input logic [31:0] max_count);
        logic [31:0] res;
        if (value == 32'd0) begin
            res = 32'd0;
        end else if (value > max_count) begin
            res = max_count - 32'd1;
        end else begin
            res = value - 32'd1;
        end
        return res;
    endfunction

endpackage

[rtl/core/max_projection_with_label_overlay.sv]
// Top level: maximum intensity projection with label overlay over a plane memory.
//
//  channel   | direction | payload                                   | handshake
//  s_axis    | in        | tdata: intensity, label_value             | tvalid/tready
//  m_axis    | out       | tdata: projected_gray, overlay_value;     | tvalid/tready
//            |           | tlast: frame_done                         |
//  cfg       | in        | cfg_index, cfg_wdata                      | cfg_valid/cfg_ready
//
// One voxel is accepted per cycle unless a stalled m_axis holds the input stage.
// The rate is set by the plane memory: one registered read at accept time and
// one write on leaving stage one, with forwarding when consecutive voxels share an entry.
// aresetn is synchronous; it clears the position counters and valid flags, resets the
// config registers but not the plane memory, as the first slice writes every entry.
// A stalled m_axis holds the output register and then the input stage.

`include "assert_macros.svh"

module max_projection_with_label_overlay #(
    parameter int MAX_WIDTH  = mplo_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mplo_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SLICES = mplo_pkg::DEF_MAX_SLICES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] intensity, [15:8] label_value
    input  logic [2*mplo_pkg::PIX_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] projected_gray, [15:8] overlay_value
    output logic [2*mplo_pkg::PIX_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mplo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mplo_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PW    = mplo_pkg::PIX_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int AW    = (DEPTH      > 1) ? $clog2(DEPTH)      : 1;

    // Configuration registers.
    logic [mplo_pkg::FW_W-1:0] fw_reg;
    logic [mplo_pkg::FH_W-1:0] fh_reg;
    logic [mplo_pkg::SC_W-1:0] sc_reg;

    logic [31:0]   w_lim32, h_lim32, s_lim32;
    logic [CW-1:0] w_lim;
    logic [RW-1:0] h_lim;
    logic [SW-1:0] s_lim;

    // Position of the next voxel.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] slice_reg, slice_next;
    logic [AW-1:0] addr_reg, addr_next;

    // Stage one: read data arrives, the update is written back.
    logic            s1_valid_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [2*PW-1:0] s1_in_reg;
    logic            s1_first_reg;
    logic            s1_out_reg;
    logic            s1_done_reg;
    logic            fwd_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic [2*PW-1:0] rd_data_reg;

    logic [2*PW-1:0] plane_mem [DEPTH];

    logic            accept;
    logic            s1_fire;
    logic            last_col, last_row, last_slice;
    logic [2*PW-1:0] base_val;
    logic [PW-1:0]   gray_new, label_new;
    logic [2*PW-1:0] new_val;

    logic            m_valid_reg;
    logic [2*PW-1:0] m_data_reg;
    logic            m_last_reg;

    always_comb begin
        w_lim32 = mplo_pkg::count_limit(32'(fw_reg), 32'(MAX_WIDTH));
        h_lim32 = mplo_pkg::count_limit(32'(fh_reg), 32'(MAX_HEIGHT));
        s_lim32 = mplo_pkg::count_limit(32'(sc_reg), 32'(MAX_SLICES));
        w_lim   = w_lim32[CW-1:0];
        h_lim   = h_lim32[RW-1:0];
        s_lim   = s_lim32[SW-1:0];
    end

    assign cfg_ready     = 1'b1;
    assign s1_fire       = s1_valid_reg && (!s1_out_reg || !m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign last_col   = (col_reg == w_lim);
    assign last_row   = (row_reg == h_lim);
    assign last_slice = (slice_reg == s_lim);

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        slice_next = slice_reg;
        addr_next  = addr_reg + AW'(1);
        if (!last_col) begin
            col_next = col_reg + CW'(1);
        end else begin
            col_next = '0;
            if (!last_row) begin
                row_next = row_reg + RW'(1);
            end else begin
                row_next  = '0;
                addr_next = '0;
                if (!last_slice) begin
                    slice_next = slice_reg + SW'(1);
                end else begin
                    slice_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg    <= mplo_pkg::RST_FRAME_WIDTH;
            fh_reg    <= mplo_pkg::RST_FRAME_HEIGHT;
            sc_reg    <= mplo_pkg::RST_SLICE_COUNT;
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
            addr_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mplo_pkg::CFG_FRAME_WIDTH: begin
                    fw_reg <= cfg_wdata[mplo_pkg::FW_W-1:0];
                end
                mplo_pkg::CFG_FRAME_HEIGHT: begin
                    fh_reg <= cfg_wdata[mplo_pkg::FH_W-1:0];
                end
                mplo_pkg::CFG_SLICE_COUNT: begin
                    sc_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
            // Any valid register write restarts the projection.
            if (cfg_index inside {mplo_pkg::CFG_FRAME_WIDTH, mplo_pkg::CFG_FRAME_HEIGHT,
                                  mplo_pkg::CFG_SLICE_COUNT}) begin
                col_reg   <= '0;
                row_reg   <= '0;
                slice_reg <= '0;
                addr_reg  <= '0;
            end
        end else if (accept) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            slice_reg <= slice_next;
            addr_reg  <= addr_next;
        end
    end

    // The linear address row * width + column stays unique while the
    // frame size is fixed, which is all the plane store needs.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= plane_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            plane_mem[s1_addr_reg] <= new_val;
        end
    end

    always_comb begin
        base_val = fwd_reg ? fwd_data_reg : rd_data_reg;
        if (s1_first_reg) begin
            gray_new  = s1_in_reg[PW-1:0];
            label_new = s1_in_reg[2*PW-1:PW];
        end else begin
            gray_new  = (s1_in_reg[PW-1:0] > base_val[PW-1:0]) ?
                        s1_in_reg[PW-1:0] : base_val[PW-1:0];
            label_new = (s1_in_reg[2*PW-1:PW] > base_val[2*PW-1:PW]) ?
                        s1_in_reg[2*PW-1:PW] : base_val[2*PW-1:PW];
        end
        new_val = {label_new, gray_new};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            // The write of the leaving voxel lands in the same cycle as this
            // read, so the memory would return the stale entry.
            fwd_reg      <= s1_fire && (s1_addr_reg == addr_reg);
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= addr_reg;
            s1_in_reg    <= s_axis_tdata;
            s1_first_reg <= (slice_reg == '0);
            s1_out_reg   <= last_slice;
            s1_done_reg  <= last_slice && last_row && last_col;
            fwd_data_reg <= new_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_out_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_out_reg) begin
            m_data_reg <= {(label_new == mplo_pkg::LABEL_MARK) ? mplo_pkg::LABEL_MARK
                                                                : gray_new,
                           gray_new};
            m_last_reg <= s1_done_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    `ASSERT_RST(a_ready_only_on_stall, aclk, aresetn,
        !s_axis_tready |-> s1_valid_reg && m_axis_tvalid && !m_axis_tready,
        "input stalled without a blocked result")
    `ASSERT_RST(a_fwd_needs_item, aclk, aresetn,
        fwd_reg |-> s1_valid_reg,
        "forwarding flag set with no voxel in flight")
    `ASSERT_RST(a_pos_in_frame, aclk, aresetn,
        (col_reg <= w_lim) && (row_reg <= h_lim) && (slice_reg <= s_lim),
        "voxel position outside the configured volume")
    `ASSERT_ANY(a_reset_clears, aclk,
        aresetn && !$past(aresetn) |-> !s1_valid_reg && !m_axis_tvalid,
        "pipeline not empty after reset")

endmodule

[sim/tb_max_projection_with_label_overlay.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the max projection and label overlay block.
module tb_max_projection_with_label_overlay;

    localparam int MAX_W        = mplo_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = mplo_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_S        = mplo_pkg::DEF_MAX_SLICES;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int NUM_STEPS    = 29;
    localparam int SHOWN_FAULTS = 10;

    // The index port has room for one register more than the block has.
    localparam logic [mplo_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [mplo_pkg::PIX_W-1:0]      pix_t;
    typedef logic [mplo_pkg::CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [mplo_pkg::PIX_W-1:0] gray;
        logic [mplo_pkg::PIX_W-1:0] overlay;
        logic                       done;
    } pixel_t;

    typedef enum logic {
        STEP_VOXEL,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t                      kind;
        logic [mplo_pkg::CFG_IDX_W-1:0]  idx;
        logic [mplo_pkg::CFG_DATA_W-1:0] value;
        logic [mplo_pkg::PIX_W-1:0]      intensity;
        logic [mplo_pkg::PIX_W-1:0]      label;
        logic                            typed;
        pixel_t                          want;
    } step_t;

    logic                              aclk;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // [7:0] intensity, [15:8] label_value
    logic [2*mplo_pkg::PIX_W-1:0]      s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [7:0] projected_gray, [15:8] overlay_value
    logic [2*mplo_pkg::PIX_W-1:0]      m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [mplo_pkg::CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [mplo_pkg::CFG_DATA_W-1:0]   cfg_wdata     = '0;

    max_projection_with_label_overlay dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Projection state mirrored from the block.
    logic [mplo_pkg::PIX_W-1:0] peak_gray  [MAX_W*MAX_H];
    logic [mplo_pkg::PIX_W-1:0] peak_label [MAX_W*MAX_H];
    int unsigned                at_col;
    int unsigned                at_row;
    int unsigned                at_slice;
    logic [mplo_pkg::FW_W-1:0]  cur_width  = mplo_pkg::RST_FRAME_WIDTH;
    logic [mplo_pkg::FH_W-1:0]  cur_height = mplo_pkg::RST_FRAME_HEIGHT;
    logic [mplo_pkg::SC_W-1:0]  cur_slices = mplo_pkg::RST_SLICE_COUNT;

    pixel_t      pending_pixels[$];
    step_t       plan [NUM_STEPS];
    int unsigned voxels_sent;
    int          fault_count;
    bit          src_idle_on   = 1'b1;
    bit          sink_stall_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic void apply_reg_write(logic [mplo_pkg::CFG_IDX_W-1:0] idx,
                                            logic [mplo_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            mplo_pkg::CFG_FRAME_WIDTH:  cur_width  = value[mplo_pkg::FW_W-1:0];
            mplo_pkg::CFG_FRAME_HEIGHT: cur_height = value[mplo_pkg::FH_W-1:0];
            mplo_pkg::CFG_SLICE_COUNT:  cur_slices = value[mplo_pkg::SC_W-1:0];
            default:                    return;
        endcase
        at_col   = 0;
        at_row   = 0;
        at_slice = 0;
    endfunction

    function automatic void project_voxel(input logic [mplo_pkg::PIX_W-1:0] intensity,
                                          input logic [mplo_pkg::PIX_W-1:0] label,
                                          output logic emits, output pixel_t px);
        int unsigned                w;
        int unsigned                h;
        int unsigned                s;
        int unsigned                addr;
        logic [mplo_pkg::PIX_W-1:0] g;
        logic [mplo_pkg::PIX_W-1:0] l;
        logic                       last_col;
        logic                       last_row;
        logic                       last_slice;
        w    = clamp_len(32'(cur_width), MAX_W);
        h    = clamp_len(32'(cur_height), MAX_H);
        s    = clamp_len(32'(cur_slices), MAX_S);
        addr = at_row * MAX_W + at_col;
        g    = intensity;
        l    = label;
        // The first slice overwrites; later slices fold in the stored maximum.
        if (at_slice != 0) begin
            if (peak_gray[addr] > g) g = peak_gray[addr];
            if (peak_label[addr] > l) l = peak_label[addr];
        end
        peak_gray[addr]  = g;
        peak_label[addr] = l;
        last_col   = (at_col + 1 >= w);
        last_row   = (at_row + 1 >= h);
        last_slice = (at_slice + 1 >= s);
        emits      = last_slice;
        px.gray    = g;
        px.overlay = (l == mplo_pkg::LABEL_MARK) ? mplo_pkg::LABEL_MARK : g;
        px.done    = last_row && last_col;
        if (!last_col) begin
            at_col++;
        end else begin
            at_col = 0;
            if (!last_row) begin
                at_row++;
            end else begin
                at_row   = 0;
                at_slice = last_slice ? 0 : at_slice + 1;
            end
        end
    endfunction

    task automatic send_voxel(input logic [mplo_pkg::PIX_W-1:0] intensity,
                              input logic [mplo_pkg::PIX_W-1:0] label,
                              input logic typed, input pixel_t want);
        int     gap;
        logic   emits;
        pixel_t px;
        gap = src_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {label, intensity};
        do @(posedge aclk); while (!s_axis_tready);
        project_voxel(intensity, label, emits, px);
        if (emits) pending_pixels.insert(pending_pixels.size(), typed ? want : px);
        voxels_sent++;
    endtask

    // Registers change only with the pipeline empty and quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mplo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mplo_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg_write(idx, value);
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [mplo_pkg::CFG_DATA_W-1:0] w_data,
                             input logic [mplo_pkg::CFG_DATA_W-1:0] h_data,
                             input logic [mplo_pkg::CFG_DATA_W-1:0] s_data,
                             input int unsigned volumes, input logic bad_write);
        int unsigned                vol;
        int unsigned                total;
        logic [mplo_pkg::PIX_W-1:0] intensity;
        logic [mplo_pkg::PIX_W-1:0] label;
        settle();
        if (bad_write) write_reg(CFG_UNUSED, cfg_word_t'($urandom));
        write_reg(mplo_pkg::CFG_FRAME_WIDTH, w_data);
        write_reg(mplo_pkg::CFG_FRAME_HEIGHT, h_data);
        write_reg(mplo_pkg::CFG_SLICE_COUNT, s_data);
        src_idle_on   = $urandom_range(0, 3) != 0;
        sink_stall_on = $urandom_range(0, 3) != 0;
        vol   = clamp_len(32'(cur_width), MAX_W) * clamp_len(32'(cur_height), MAX_H)
              * clamp_len(32'(cur_slices), MAX_S);
        total = volumes * vol;
        // A trailing partial volume leaves the block mid-frame for the next restart.
        if (vol > 1 && $urandom_range(0, 3) == 0) total += $urandom_range(1, vol - 1);
        repeat (total) begin
            case ($urandom_range(0, 7))
                0:       intensity = 8'h00;
                1:       intensity = 8'hFF;
                default: intensity = pix_t'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       label = mplo_pkg::LABEL_MARK;
                1:       label = mplo_pkg::LABEL_MARK - 8'd1;
                2:       label = 8'h00;
                default: label = pix_t'($urandom);
            endcase
            send_voxel(intensity, label, 1'b0, '0);
        end
    endtask

    task automatic note_fault(input string what);
        if (fault_count < SHOWN_FAULTS) $display("%0t: %s", $realtime, what);
        fault_count++;
    endtask

    initial begin
        int     stall;
        pixel_t got;
        pixel_t want;
        wait (aresetn);
        forever begin
            stall = sink_stall_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            got = {m_axis_tdata[mplo_pkg::PIX_W-1:0],
                   m_axis_tdata[2*mplo_pkg::PIX_W-1:mplo_pkg::PIX_W], m_axis_tlast};
            if (pending_pixels.size() == 0) begin
                note_fault($sformatf("unexpected result gray %0d overlay %0d last %0b",
                                     got.gray, got.overlay, got.done));
            end else begin
                want = pending_pixels.pop_front();
                if (got.gray !== want.gray || got.overlay !== want.overlay
                        || got.done !== want.done) begin
                    note_fault($sformatf({"mismatch: expected gray %0d overlay %0d last %0b,",
                                          " got gray %0d overlay %0d last %0b"},
                                         want.gray, want.overlay, want.done,
                                         got.gray, got.overlay, got.done));
                end
            end
        end
    end

    initial begin
        int unsigned                     start;
        logic [mplo_pkg::CFG_DATA_W-1:0] w_data;
        logic [mplo_pkg::CFG_DATA_W-1:0] h_data;
        logic [mplo_pkg::CFG_DATA_W-1:0] s_data;

        // Reset geometry emits every voxel as it comes.
        plan[0]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0};
        plan[1]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0};
        plan[2]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h07, 8'hFF, 1'b1, 8'h07, 8'hFF, 1'b0};
        plan[3]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'hC8, 8'hFE, 1'b1, 8'hC8, 8'hC8, 1'b0};
        // Zero in every register counts as one: a single pixel, single slice image.
        plan[4]  = {STEP_WRITE, mplo_pkg::CFG_FRAME_WIDTH,  13'd0, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[5]  = {STEP_WRITE, mplo_pkg::CFG_FRAME_HEIGHT, 13'd0, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[6]  = {STEP_WRITE, mplo_pkg::CFG_SLICE_COUNT,  13'd0, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[7]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h5A, 8'hA5, 1'b1, 8'h5A, 8'h5A, 1'b1};
        plan[8]  = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'hA5, 8'h5A, 1'b1, 8'hA5, 8'hA5, 1'b1};
        plan[9]  = {STEP_WRITE, mplo_pkg::CFG_FRAME_WIDTH,  13'd2, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[10] = {STEP_WRITE, mplo_pkg::CFG_FRAME_HEIGHT, 13'd1, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[11] = {STEP_WRITE, mplo_pkg::CFG_SLICE_COUNT,  13'd2, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[12] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h0A, 8'hFF, 1'b0, 17'd0};
        plan[13] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'hC8, 8'h03, 1'b0, 17'd0};
        plan[14] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h14, 8'h00, 1'b0, 17'd0};
        plan[15] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h64, 8'hFE, 1'b0, 17'd0};
        plan[16] = {STEP_WRITE, mplo_pkg::CFG_SLICE_COUNT,  13'd3, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[17] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h30, 8'h10, 1'b0, 17'd0};
        plan[18] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h31, 8'h11, 1'b0, 17'd0};
        plan[19] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h32, 8'h12, 1'b0, 17'd0};
        // A write to the unused index mid-frame must not restart the projection.
        plan[20] = {STEP_WRITE, CFG_UNUSED, 13'h1FFF, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[21] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h33, 8'hFF, 1'b0, 17'd0};
        // A real write mid-frame restarts at slice zero.
        plan[22] = {STEP_WRITE, mplo_pkg::CFG_SLICE_COUNT,  13'd3, 8'h00, 8'h00, 1'b0, 17'd0};
        plan[23] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h01, 8'h00, 1'b0, 17'd0};
        plan[24] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h02, 8'h00, 1'b0, 17'd0};
        plan[25] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'hFF, 8'hFE, 1'b0, 17'd0};
        plan[26] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h00, 8'h01, 1'b0, 17'd0};
        plan[27] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h80, 8'hFF, 1'b0, 17'd0};
        plan[28] = {STEP_VOXEL, CFG_UNUSED, 13'd0, 8'h7F, 8'hFE, 1'b0, 17'd0};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_WRITE) begin
                settle();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_voxel(plan[i].intensity, plan[i].label, plan[i].typed, plan[i].want);
            end
        end

        // Register values above the maximum saturate to it.
        run_phase(13'h1FFF, 13'h0001, 13'h0002, 1, 1'b0);
        run_phase(13'h0001, 13'h1FFF, 13'h0002, 1, 1'b0);
        run_phase(13'h0001, 13'h0001, 13'h1FFF, 1, 1'b1);

        start = voxels_sent;
        while (voxels_sent - start < RANDOM_ITEMS) begin
            // Bits above the nine-bit size fields are don't-care and get random values.
            w_data      = cfg_word_t'($urandom);
            w_data[8:0] = 9'($urandom_range(0, 8));
            h_data      = cfg_word_t'($urandom);
            h_data[8:0] = 9'($urandom_range(0, 8));
            s_data      = cfg_word_t'($urandom_range(0, 6));
            run_phase(w_data, h_data, s_data, $urandom_range(1, 3), $urandom_range(0, 3) == 0);
        end

        settle();
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
